// ===== rtl/sws_pkg.sv =====
// shared types and constants for the sliding window smoother
// no dependencies; imported by every module of the block but sws_ram
package sws_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int PTR_W       = $clog2(WINDOW_MAX);
  localparam int LEN_W       = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W       = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int DCNT_W      = $clog2(SUM_W + 1);

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_LEN_W   = 7;
  localparam int MODE_W      = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_MEAN = 2'd0,
    MODE_MAX  = 2'd1,
    MODE_ENV  = 2'd2
  } mode_e;

  localparam logic [MODE_W-1:0]      MODE_RESET  = MODE_MEAN;
  localparam logic [CFG_LEN_W-1:0]   LEN_RESET   = 7'd8;
  localparam logic [CFG_DATA_W-1:0]  FLOOR_RESET = 16'hFC18;  // -1000

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_DIVSET,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic scan_init;
    logic scan_issue;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic go;
    logic scan_last;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/sws_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module sws_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sws_ctrl.sv =====
// sequencer of the smoother: accept, window check, scan, divide, result
// depends on sws_pkg
module sws_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sws_pkg::status_t status_i,
  output sws_pkg::cmd_t    cmd_o
);
  import sws_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.go) begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      // last read word lands in the accumulators here
      ST_DRAIN: begin
        state_d = ST_DIVSET;
      end
      ST_DIVSET: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sws_datapath.sv =====
// datapath of the smoother: config registers, window store, scan
// accumulators, serial divider and output register
// depends on sws_pkg and sws_ram
module sws_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sws_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sws_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic [sws_pkg::SAMPLE_BITS-1:0]      sample_i,
  input  logic                                 first_i,
  input  sws_pkg::cmd_t                        cmd_i,
  output sws_pkg::status_t                     status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [sws_pkg::SAMPLE_BITS-1:0]      out_data_o
);
  import sws_pkg::*;

  logic [MODE_W-1:0]     mode_q;
  logic [CFG_LEN_W-1:0]  win_len_q;
  logic [CFG_DATA_W-1:0] floor_q;

  logic [PTR_W-1:0] wp_q, wp_base, rd_ptr_q;
  logic [LEN_W-1:0] fill_q, fill_base, len_eff, scan_cnt_q;
  logic             rd_vld_q;
  logic [SAMPLE_BITS-1:0] rdata;

  logic signed [SUM_W-1:0]       sum_q;
  logic signed [SAMPLE_BITS-1:0] max_q, oldest_q, rdata_s, mean, result;
  logic                          neg_q;
  logic [SUM_W-1:0]              quo_q, mean_full;
  logic [LEN_W-1:0]              rem_q;
  logic [LEN_W:0]                trial;
  logic [DCNT_W-1:0]             dcnt_q;
  logic                          out_valid_q;
  logic [SAMPLE_BITS-1:0]        out_data_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_RESET;
      win_len_q <= LEN_RESET;
      floor_q   <= FLOOR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE:  mode_q    <= cfg_data_i[MODE_W-1:0];
        CFG_LEN:   win_len_q <= cfg_data_i[CFG_LEN_W-1:0];
        CFG_FLOOR: floor_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (win_len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(win_len_q) > WINDOW_MAX) begin
      len_eff = LEN_W'(WINDOW_MAX);
    end else begin
      len_eff = LEN_W'(win_len_q);
    end
  end

  // a first request starts the window over
  assign wp_base   = first_i ? '0 : wp_q;
  assign fill_base = first_i ? '0 : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (cmd_i.accept) begin
      wp_q   <= (int'(wp_base) == WINDOW_MAX - 1) ? '0 : wp_base + 1'b1;
      fill_q <= (int'(fill_base) < WINDOW_MAX) ? fill_base + 1'b1 : fill_base;
    end
  end

  sws_ram #(
    .W    (SAMPLE_BITS),
    .DEPTH(WINDOW_MAX)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept),
    .waddr_i(wp_base),
    .wdata_i(sample_i),
    .raddr_i(rd_ptr_q),
    .rdata_o(rdata)
  );

  // scan walks from the newest sample back to the oldest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      rd_ptr_q   <= (wp_q == '0) ? PTR_W'(WINDOW_MAX - 1) : wp_q - 1'b1;
      scan_cnt_q <= '0;
    end else if (cmd_i.scan_issue) begin
      rd_ptr_q   <= (rd_ptr_q == '0) ? PTR_W'(WINDOW_MAX - 1) : rd_ptr_q - 1'b1;
      scan_cnt_q <= scan_cnt_q + 1'b1;
    end
  end

  assign rdata_s = signed'(rdata);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      sum_q <= '0;
      max_q <= signed'(floor_q);
    end else if (rd_vld_q) begin
      sum_q    <= sum_q + {{(SUM_W-SAMPLE_BITS){rdata[SAMPLE_BITS-1]}}, rdata};
      max_q    <= (rdata_s > max_q) ? rdata_s : max_q;
      oldest_q <= rdata_s;
    end
  end

  // restoring divide of the magnitude, one quotient bit a cycle
  assign trial = {rem_q, quo_q[SUM_W-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      neg_q  <= sum_q[SUM_W-1];
      quo_q  <= sum_q[SUM_W-1] ? unsigned'(-sum_q) : unsigned'(sum_q);
      rem_q  <= '0;
      dcnt_q <= DCNT_W'(SUM_W);
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, len_eff}) begin
        rem_q <= LEN_W'(trial - {1'b0, len_eff});
        quo_q <= {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[LEN_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b0};
      end
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  assign mean_full = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign mean      = signed'(mean_full[SAMPLE_BITS-1:0]);

  always_comb begin
    case (mode_q)
      MODE_MAX: result = max_q;
      MODE_ENV: result = (oldest_q > mean) ? oldest_q : mean;
      default:  result = mean;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= unsigned'(result);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign status_o.go        = (fill_q >= len_eff) &&
                              ((mode_q == MODE_MEAN) || (mode_q == MODE_MAX) ||
                               (mode_q == MODE_ENV));
  assign status_o.scan_last = (scan_cnt_q == len_eff - 1'b1);
  assign status_o.div_done  = (dcnt_q == '0);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) <= WINDOW_MAX)
    else $error("fill count above window depth");

  a_div_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_init |-> !rd_vld_q && !cmd_i.scan_issue)
    else $error("divide started before scan finished");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> rem_q < len_eff)
    else $error("divider remainder not below divisor");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !out_valid_q || out_ready_i)
    else $error("result overwritten before taken");

endmodule

// ===== rtl/sliding_window_smoother.sv =====
// Sliding window smoother: moving mean, moving max (floored) or envelope of
// mean and oldest sample over the last window_length samples. One request
// is taken at a time; when the window is full a request goes through accept,
// check, one store read per window sample, read drain, divider setup, the
// divide steps and a finish step, and result load before the next accept,
// longer while the previous result still waits at the output; when no
// result is due it goes from check straight back to idle. The scan over the
// single-port-read window store and the bit-serial divider set the pace.
// A finished result waits in an output register while the next request is
// taken. Depends on sws_pkg, sws_ctrl, sws_datapath and sws_ram.
module sliding_window_smoother (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [sws_pkg::SAMPLE_BITS-1:0]      s_axis_tdata,   // [15:0] sample
  input  logic [0:0]                           s_axis_tuser,   // [0] first
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [sws_pkg::SAMPLE_BITS-1:0]      m_axis_tdata,   // [15:0] smoothed
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sws_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sws_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import sws_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  sws_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  sws_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (s_axis_tdata),
    .first_i    (s_axis_tuser[0]),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule
